>>> rtl/lldp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lldp_pkg;

    // Defaults for top-level parameters
    localparam int PORT_COUNT_DEF = 64;

    // Decoupling queue between parser and result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // TTL TLV value length that is accepted
    localparam logic [8:0] TTL_LEN = 9'd2;

    // TLV type codes
    localparam logic [6:0] TLV_END       = 7'd0;
    localparam logic [6:0] TLV_CHASSIS   = 7'd1;
    localparam logic [6:0] TLV_PORT_ID   = 7'd2;
    localparam logic [6:0] TLV_TTL       = 7'd3;
    localparam logic [6:0] TLV_PORT_DESC = 7'd4;
    localparam logic [6:0] TLV_SYS_NAME  = 7'd5;
    localparam logic [6:0] TLV_SYS_DESC  = 7'd6;

    // Result tlv_code values
    localparam logic [2:0] CODE_CHASSIS   = 3'd0;
    localparam logic [2:0] CODE_PORT_ID   = 3'd1;
    localparam logic [2:0] CODE_SYS_NAME  = 3'd2;
    localparam logic [2:0] CODE_SYS_DESC  = 3'd3;
    localparam logic [2:0] CODE_PORT_DESC = 3'd4;

    // Result kinds
    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    localparam logic [1:0] VRD_UPDATE    = 2'd0;
    localparam logic [1:0] VRD_REMOVE    = 2'd1;
    localparam logic [1:0] VRD_MISSING   = 2'd2;
    localparam logic [1:0] VRD_MALFORMED = 2'd3;

    // found flag bits
    localparam int SEEN_CHASSIS = 0;
    localparam int SEEN_PORT_ID = 1;
    localparam int SEEN_TTL     = 2;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HDR_HI,
        PH_HDR_LO,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
        logic [5:0] rx_port;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic        result_kind;
        logic [2:0]  tlv_code;
        logic [7:0]  value_octet;
        logic [8:0]  value_offset;
        logic [1:0]  verdict;
        logic [15:0] ttl_seconds;
        logic [7:0]  chassis_subtype;
        logic [7:0]  port_subtype;
        logic [5:0]  port_out;
        logic        result_last;
    } out_item_t;

    // Classified work for one byte: an optional value result and an optional verdict
    typedef struct packed {
        logic        val_valid;
        logic [2:0]  val_code;
        logic [7:0]  val_octet;
        logic [8:0]  val_offset;
        logic        vrd_valid;
        logic [1:0]  verdict;
        logic [15:0] ttl;
        logic [7:0]  chassis_sub;
        logic [7:0]  port_sub;
        logic [5:0]  port;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/lldp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lldp_front #(
    parameter int PORT_COUNT = lldp_pkg::PORT_COUNT_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire lldp_pkg::in_item_t in_item,
    output logic                  push,
    output lldp_pkg::entry_t      push_entry
);
    import lldp_pkg::*;

    phase_t      phase_reg, phase_next, phase_mid;
    logic [7:0]  header_high_reg, header_high_next, header_high_mid;
    logic [6:0]  cur_type_reg, cur_type_next, cur_type_mid;
    logic [8:0]  bytes_left_reg, bytes_left_next, bytes_left_mid;
    logic [8:0]  byte_pos_reg, byte_pos_next, byte_pos_mid;
    logic [2:0]  found_reg, found_next, found_mid;
    logic [15:0] ttl_value_reg, ttl_value_next, ttl_value_mid;
    logic [15:0] ttl_stage_reg, ttl_stage_next, ttl_stage_mid;
    logic [7:0]  chassis_sub_reg, chassis_sub_next, chassis_sub_mid;
    logic [7:0]  port_sub_reg, port_sub_next, port_sub_mid;

    logic        port_ok;
    logic        step;
    logic        frame_end;
    logic        val_emit;
    logic [2:0]  val_code;
    logic [8:0]  val_offset;
    logic        malformed;
    logic [1:0]  verdict;

    // Drop bytes from ports beyond the configured count
    assign port_ok   = int'(in_item.rx_port) < PORT_COUNT;
    assign step      = in_fire && port_ok;
    assign frame_end = step && in_item.frame_last;

    // Walk the TLV structure one byte at a time
    always_comb begin
        phase_mid       = phase_reg;
        header_high_mid = header_high_reg;
        cur_type_mid    = cur_type_reg;
        bytes_left_mid  = bytes_left_reg;
        byte_pos_mid    = byte_pos_reg;
        found_mid       = found_reg;
        ttl_value_mid   = ttl_value_reg;
        ttl_stage_mid   = ttl_stage_reg;
        chassis_sub_mid = chassis_sub_reg;
        port_sub_mid    = port_sub_reg;
        val_emit        = 1'b0;
        val_code        = CODE_CHASSIS;
        val_offset      = byte_pos_reg;
        if (step) begin
            case (phase_reg)
                PH_HDR_HI: begin
                    header_high_mid = in_item.data_byte;
                    phase_mid       = PH_HDR_LO;
                end
                PH_HDR_LO: begin
                    cur_type_mid   = header_high_reg[7:1];
                    bytes_left_mid = {header_high_reg[0], in_item.data_byte};
                    byte_pos_mid   = 9'd0;
                    if (header_high_reg[7:1] == TLV_END) begin
                        phase_mid = PH_DONE;
                    end else if ({header_high_reg[0], in_item.data_byte} == 9'd0) begin
                        phase_mid = PH_HDR_HI;
                    end else begin
                        phase_mid = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    case (cur_type_reg)
                        TLV_CHASSIS: begin
                            if (byte_pos_reg == 9'd0) begin
                                chassis_sub_mid         = in_item.data_byte;
                                found_mid[SEEN_CHASSIS] = 1'b1;
                            end else begin
                                val_emit   = 1'b1;
                                val_code   = CODE_CHASSIS;
                                val_offset = byte_pos_reg - 9'd1;
                            end
                        end
                        TLV_PORT_ID: begin
                            if (byte_pos_reg == 9'd0) begin
                                port_sub_mid            = in_item.data_byte;
                                found_mid[SEEN_PORT_ID] = 1'b1;
                            end else begin
                                val_emit   = 1'b1;
                                val_code   = CODE_PORT_ID;
                                val_offset = byte_pos_reg - 9'd1;
                            end
                        end
                        TLV_TTL: begin
                            ttl_stage_mid = {ttl_stage_reg[7:0], in_item.data_byte};
                        end
                        TLV_PORT_DESC: begin
                            val_emit = 1'b1;
                            val_code = CODE_PORT_DESC;
                        end
                        TLV_SYS_NAME: begin
                            val_emit = 1'b1;
                            val_code = CODE_SYS_NAME;
                        end
                        TLV_SYS_DESC: begin
                            val_emit = 1'b1;
                            val_code = CODE_SYS_DESC;
                        end
                        default: begin
                            val_emit = 1'b0;
                        end
                    endcase
                    byte_pos_mid   = byte_pos_reg + 9'd1;
                    bytes_left_mid = bytes_left_reg - 9'd1;
                    // Close the TLV; latch TTL only for an exact two-byte value
                    if (bytes_left_mid == 9'd0) begin
                        if (cur_type_reg == TLV_TTL && byte_pos_mid == TTL_LEN) begin
                            ttl_value_mid       = ttl_stage_mid;
                            found_mid[SEEN_TTL] = 1'b1;
                        end
                        phase_mid = PH_HDR_HI;
                    end
                end
                PH_DONE: begin
                    if (bytes_left_reg != 9'd0) begin
                        bytes_left_mid = bytes_left_reg - 9'd1;
                    end
                end
                default: begin
                    phase_mid = PH_HDR_HI;
                end
            endcase
        end
    end

    // Clear per-frame state after the last byte
    always_comb begin
        if (frame_end) begin
            phase_next       = PH_HDR_HI;
            header_high_next = 8'd0;
            cur_type_next    = 7'd0;
            bytes_left_next  = 9'd0;
            byte_pos_next    = 9'd0;
            found_next       = 3'd0;
            ttl_value_next   = 16'd0;
            ttl_stage_next   = 16'd0;
            chassis_sub_next = 8'd0;
            port_sub_next    = 8'd0;
        end else begin
            phase_next       = phase_mid;
            header_high_next = header_high_mid;
            cur_type_next    = cur_type_mid;
            bytes_left_next  = bytes_left_mid;
            byte_pos_next    = byte_pos_mid;
            found_next       = found_mid;
            ttl_value_next   = ttl_value_mid;
            ttl_stage_next   = ttl_stage_mid;
            chassis_sub_next = chassis_sub_mid;
            port_sub_next    = port_sub_mid;
        end
    end

    // Rank the verdict: malformed, missing mandatory, then TTL zero
    always_comb begin
        malformed = (phase_mid == PH_VALUE || phase_mid == PH_DONE) &&
                    (bytes_left_mid != 9'd0);
        if (malformed) begin
            verdict = VRD_MALFORMED;
        end else if (found_mid != 3'b111) begin
            verdict = VRD_MISSING;
        end else if (ttl_value_mid == 16'd0) begin
            verdict = VRD_REMOVE;
        end else begin
            verdict = VRD_UPDATE;
        end
    end

    // Build the queue entry for this byte
    always_comb begin
        push_entry.val_valid   = val_emit;
        push_entry.val_code    = val_code;
        push_entry.val_octet   = in_item.data_byte;
        push_entry.val_offset  = val_offset;
        push_entry.vrd_valid   = frame_end;
        push_entry.verdict     = verdict;
        push_entry.ttl         = ttl_value_mid;
        push_entry.chassis_sub = chassis_sub_mid;
        push_entry.port_sub    = port_sub_mid;
        push_entry.port        = in_item.rx_port;
        push                   = step && (val_emit || frame_end);
    end

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR_HI;
            header_high_reg <= 8'd0;
            cur_type_reg    <= 7'd0;
            bytes_left_reg  <= 9'd0;
            byte_pos_reg    <= 9'd0;
            found_reg       <= 3'd0;
            ttl_value_reg   <= 16'd0;
            ttl_stage_reg   <= 16'd0;
            chassis_sub_reg <= 8'd0;
            port_sub_reg    <= 8'd0;
        end else begin
            phase_reg       <= phase_next;
            header_high_reg <= header_high_next;
            cur_type_reg    <= cur_type_next;
            bytes_left_reg  <= bytes_left_next;
            byte_pos_reg    <= byte_pos_next;
            found_reg       <= found_next;
            ttl_value_reg   <= ttl_value_next;
            ttl_stage_reg   <= ttl_stage_next;
            chassis_sub_reg <= chassis_sub_next;
            port_sub_reg    <= port_sub_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lldp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lldp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire lldp_pkg::entry_t push_entry,
    input  wire logic             pop,
    output lldp_pkg::entry_t      head_entry,
    output logic                  head_valid,
    output logic                  full
);
    import lldp_pkg::*;

    entry_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lldp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lldp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lldp_pkg::entry_t head_entry,
    input  wire logic             head_valid,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lldp_pkg::out_item_t   m_data
);
    import lldp_pkg::*;

    out_item_t m_data_reg, m_data_next;
    logic      m_valid_reg, m_valid_next;
    logic      val_done_reg, val_done_next;
    logic      load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = head_valid && (!m_valid_reg || m_ready);

    // Expand an entry into a value transfer and/or a verdict transfer
    always_comb begin
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        val_done_next = val_done_reg;
        pop           = 1'b0;
        if (load) begin
            m_valid_next = 1'b1;
            if (head_entry.val_valid && !val_done_reg) begin
                m_data_next.result_kind     = KIND_VALUE;
                m_data_next.tlv_code        = head_entry.val_code;
                m_data_next.value_octet     = head_entry.val_octet;
                m_data_next.value_offset    = head_entry.val_offset;
                m_data_next.verdict         = 2'd0;
                m_data_next.ttl_seconds     = 16'd0;
                m_data_next.chassis_subtype = 8'd0;
                m_data_next.port_subtype    = 8'd0;
                m_data_next.port_out        = head_entry.port;
                m_data_next.result_last     = !head_entry.vrd_valid;
                if (head_entry.vrd_valid) begin
                    val_done_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                m_data_next.result_kind     = KIND_VERDICT;
                m_data_next.tlv_code        = 3'd0;
                m_data_next.value_octet     = 8'd0;
                m_data_next.value_offset    = 9'd0;
                m_data_next.verdict         = head_entry.verdict;
                m_data_next.ttl_seconds     = head_entry.ttl;
                m_data_next.chassis_subtype = head_entry.chassis_sub;
                m_data_next.port_subtype    = head_entry.port_sub;
                m_data_next.port_out        = head_entry.port;
                m_data_next.result_last     = 1'b1;
                val_done_next               = 1'b0;
                pop                         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            val_done_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            val_done_reg <= val_done_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/lldp_tlv_parser_unit.sv
// A result travels from its byte transfer to m_ through the queue write and
// then the output register.
// Throughput: one byte per cycle; a byte that carries both a value result and
// a verdict yields two output transfers, absorbed by a four-entry queue between
// the TLV parser and the result sequencer; s_ready drops while the queue is full.
// Reset: synchronous, active-low aresetn clears the parser state, the queue
// and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module lldp_tlv_parser_unit #(
    parameter int PORT_COUNT = lldp_pkg::PORT_COUNT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lldp_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lldp_pkg::out_item_t     m_data
);
    import lldp_pkg::*;

    logic   in_fire;
    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t head_entry;
    logic   head_valid;
    logic   full;

    // Accept a byte whenever the queue has room for its entry
    assign s_ready = !full;
    assign in_fire = s_valid && s_ready;

    lldp_front #(
        .PORT_COUNT(PORT_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_item    (s_data),
        .push       (push),
        .push_entry (push_entry)
    );

    lldp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .full       (full)
    );

    lldp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/lldp_tlv_parser_unit_tb.sv
`timescale 1ns / 1ps

module lldp_tlv_parser_unit_tb;
    import lldp_pkg::*;

    localparam int PORTS       = PORT_COUNT_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    lldp_tlv_parser_unit #(.PORT_COUNT(PORTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Byte stream to send and results still owed by the block;
    // each queue keeps its newest entry at the front
    in_item_t  byte_stream[$];
    logic [7:0] frame_bytes[$];
    out_item_t expected_results[$];

    int total_items    = 0;
    int directed_items = 0;
    int issued_count   = 0;
    int accepted_count = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int long_budget    = 2;

    // Sender pause points: wait for every result before going on
    int pause_mark[2];
    int pause_idx      = 0;

    // Receiver hold-off
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // Shadow of the parser state
    phase_t      sh_phase;
    logic [7:0]  sh_hdr_hi;
    logic [6:0]  sh_type;
    logic [8:0]  sh_left;
    logic [8:0]  sh_pos;
    logic [2:0]  sh_found;
    logic [15:0] sh_ttl;
    logic [15:0] sh_ttl_stage;
    logic [7:0]  sh_csub;
    logic [7:0]  sh_psub;

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Clear all per-frame state
    task automatic clear_frame_state();
        sh_phase     = PH_HDR_HI;
        sh_hdr_hi    = '0;
        sh_type      = '0;
        sh_left      = '0;
        sh_pos       = '0;
        sh_found     = '0;
        sh_ttl       = '0;
        sh_ttl_stage = '0;
        sh_csub      = '0;
        sh_psub      = '0;
    endtask

    // Advance the TLV walk by one byte and queue the results it causes
    task automatic parse_byte(input in_item_t it);
        out_item_t   res[2];
        int          n;
        logic        emit;
        logic [2:0]  code;
        logic [8:0]  off;
        logic        malformed;
        logic [7:0]  b;
        n = 0;
        b = it.data_byte;
        if (int'(it.rx_port) >= PORTS) return;

        case (sh_phase)
            PH_HDR_HI: begin
                sh_hdr_hi = b;
                sh_phase  = PH_HDR_LO;
            end
            PH_HDR_LO: begin
                sh_type = sh_hdr_hi[7:1];
                sh_left = {sh_hdr_hi[0], b};
                sh_pos  = '0;
                if (sh_type == TLV_END)
                    sh_phase = PH_DONE;
                else if (sh_left == 9'd0)
                    sh_phase = PH_HDR_HI;
                else
                    sh_phase = PH_VALUE;
            end
            PH_VALUE: begin
                emit = 1'b0;
                code = CODE_CHASSIS;
                off  = sh_pos;
                case (sh_type)
                    TLV_CHASSIS: begin
                        if (sh_pos == 9'd0) begin
                            sh_csub = b;
                            sh_found[SEEN_CHASSIS] = 1'b1;
                        end else begin
                            emit = 1'b1;
                            code = CODE_CHASSIS;
                            off  = sh_pos - 9'd1;
                        end
                    end
                    TLV_PORT_ID: begin
                        if (sh_pos == 9'd0) begin
                            sh_psub = b;
                            sh_found[SEEN_PORT_ID] = 1'b1;
                        end else begin
                            emit = 1'b1;
                            code = CODE_PORT_ID;
                            off  = sh_pos - 9'd1;
                        end
                    end
                    TLV_TTL:       sh_ttl_stage = {sh_ttl_stage[7:0], b};
                    TLV_PORT_DESC: begin emit = 1'b1; code = CODE_PORT_DESC; end
                    TLV_SYS_NAME:  begin emit = 1'b1; code = CODE_SYS_NAME; end
                    TLV_SYS_DESC:  begin emit = 1'b1; code = CODE_SYS_DESC; end
                    default: ;
                endcase
                if (emit) begin
                    res[n] = '0;
                    res[n].result_kind  = KIND_VALUE;
                    res[n].tlv_code     = code;
                    res[n].value_octet  = b;
                    res[n].value_offset = off;
                    res[n].port_out     = it.rx_port;
                    n++;
                end
                sh_pos  = sh_pos + 9'd1;
                sh_left = sh_left - 9'd1;
                if (sh_left == 9'd0) begin
                    if (sh_type == TLV_TTL && sh_pos == TTL_LEN) begin
                        sh_ttl = sh_ttl_stage;
                        sh_found[SEEN_TTL] = 1'b1;
                    end
                    sh_phase = PH_HDR_HI;
                end
            end
            default: begin
                // After End TLV: count down its length only
                if (sh_left != 9'd0) sh_left = sh_left - 9'd1;
            end
        endcase

        if (it.frame_last) begin
            malformed = (sh_phase == PH_VALUE || sh_phase == PH_DONE) && sh_left != 9'd0;
            res[n] = '0;
            res[n].result_kind     = KIND_VERDICT;
            if (malformed)
                res[n].verdict = VRD_MALFORMED;
            else if (sh_found != 3'b111)
                res[n].verdict = VRD_MISSING;
            else if (sh_ttl == 16'd0)
                res[n].verdict = VRD_REMOVE;
            else
                res[n].verdict = VRD_UPDATE;
            res[n].ttl_seconds     = sh_ttl;
            res[n].chassis_subtype = sh_csub;
            res[n].port_subtype    = sh_psub;
            res[n].port_out        = it.rx_port;
            n++;
            clear_frame_state();
        end

        if (n > 0) res[n-1].result_last = 1'b1;
        for (int i = 0; i < n; i++) expected_results.push_front(res[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Compare one transfer against the oldest expected result
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with none pending", 32'(got.result_kind), 0);
            return;
        end
        want = expected_results.pop_back();
        if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
        if (got.tlv_code !== want.tlv_code)
            report_mismatch("tlv_code", 32'(got.tlv_code), 32'(want.tlv_code));
        if (got.value_octet !== want.value_octet)
            report_mismatch("value_octet", 32'(got.value_octet), 32'(want.value_octet));
        if (got.value_offset !== want.value_offset)
            report_mismatch("value_offset", 32'(got.value_offset), 32'(want.value_offset));
        if (got.verdict !== want.verdict)
            report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
        if (got.ttl_seconds !== want.ttl_seconds)
            report_mismatch("ttl_seconds", 32'(got.ttl_seconds), 32'(want.ttl_seconds));
        if (got.chassis_subtype !== want.chassis_subtype)
            report_mismatch("chassis_subtype", 32'(got.chassis_subtype),
                            32'(want.chassis_subtype));
        if (got.port_subtype !== want.port_subtype)
            report_mismatch("port_subtype", 32'(got.port_subtype), 32'(want.port_subtype));
        if (got.port_out !== want.port_out)
            report_mismatch("port_out", 32'(got.port_out), 32'(want.port_out));
        if (got.result_last !== want.result_last)
            report_mismatch("result_last", 32'(got.result_last), 32'(want.result_last));
    endtask

    // Frame building
    task automatic push_hdr(input logic [6:0] kind, input logic [8:0] len);
        frame_bytes.push_front({kind, len[8]});
        frame_bytes.push_front(len[7:0]);
    endtask

    task automatic add_tlv(input logic [6:0] kind, input int len);
        push_hdr(kind, len[8:0]);
        for (int i = 0; i < len; i++) frame_bytes.push_front(8'($urandom_range(255)));
    endtask

    task automatic add_ttl();
        int r;
        logic [15:0] v;
        r = $urandom_range(99);
        if (r < 20)      v = 16'h0000;
        else if (r < 30) v = 16'hFFFF;
        else             v = 16'($urandom_range(65535));
        push_hdr(TLV_TTL, TTL_LEN);
        frame_bytes.push_front(v[15:8]);
        frame_bytes.push_front(v[7:0]);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 3 && long_budget > 0) begin
            long_budget--;
            return $urandom_range(256, 511);
        end
        if (r < 10) return 0;
        return $urandom_range(1, 8);
    endfunction

    // Move the built frame into the byte stream, last flag on its final byte
    task automatic queue_frame();
        in_item_t   it;
        logic [5:0] home;
        home = 6'($urandom_range(63));
        for (int i = frame_bytes.size() - 1; i >= 0; i--) begin
            it.data_byte  = frame_bytes[i];
            it.frame_last = (i == 0);
            it.rx_port    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : home;
            byte_stream.push_front(it);
        end
        frame_bytes.delete();
    endtask

    task automatic build_wellformed();
        int n_extra;
        int r;
        int k;
        if ($urandom_range(9) != 0) add_tlv(TLV_CHASSIS, pick_len());
        if ($urandom_range(9) != 0) add_tlv(TLV_PORT_ID, pick_len());
        if ($urandom_range(9) != 0) add_ttl();
        n_extra = $urandom_range(0, 3);
        for (int i = 0; i < n_extra; i++) begin
            r = $urandom_range(9);
            case (r)
                0, 1: add_tlv(TLV_PORT_DESC, pick_len());
                2, 3: add_tlv(TLV_SYS_NAME, pick_len());
                4, 5: add_tlv(TLV_SYS_DESC, pick_len());
                6:    add_tlv(7'($urandom_range(7, 127)), pick_len());
                7: begin
                    // TTL with a length other than two
                    k = $urandom_range(0, 3);
                    if (k >= 2) k++;
                    add_tlv(TLV_TTL, k);
                end
                8:    add_tlv(TLV_CHASSIS, $urandom_range(0, 3));
                default: add_tlv(TLV_PORT_ID, $urandom_range(0, 3));
            endcase
        end
        r = $urandom_range(99);
        if (r < 80) begin
            push_hdr(TLV_END, 9'd0);
        end else if (r < 90) begin
            // End TLV with a body, sometimes cut short
            k = $urandom_range(1, 4);
            push_hdr(TLV_END, 9'(k));
            if ($urandom_range(1) == 0) k = k - 1;
            for (int i = 0; i < k; i++) frame_bytes.push_front(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 15) frame_bytes.push_front(8'($urandom_range(255)));
        if (frame_bytes.size() == 0) frame_bytes.push_front(8'($urandom_range(255)));
    endtask

    task automatic build_stimulus();
        int r;
        int keep;
        // Full frame, TTL zero
        push_hdr(TLV_CHASSIS, 9'd2);
        frame_bytes.push_front(8'hFF);
        frame_bytes.push_front(8'h00);
        push_hdr(TLV_PORT_ID, 9'd2);
        frame_bytes.push_front(8'h00);
        frame_bytes.push_front(8'hFF);
        push_hdr(TLV_TTL, TTL_LEN);
        frame_bytes.push_front(8'h00);
        frame_bytes.push_front(8'h00);
        push_hdr(TLV_END, 9'd0);
        queue_frame();
        // Lone header high byte
        frame_bytes.push_front(8'hFF);
        queue_frame();
        // Length runs past the frame end
        push_hdr(TLV_CHASSIS, 9'd5);
        frame_bytes.push_front(8'h07);
        queue_frame();
        // Value byte that is also the last byte
        push_hdr(TLV_SYS_NAME, 9'd1);
        frame_bytes.push_front(8'hAB);
        queue_frame();
        directed_items = byte_stream.size();

        while (byte_stream.size() < directed_items + 850) begin
            r = $urandom_range(99);
            if (r < 70) begin
                build_wellformed();
            end else if (r < 85) begin
                build_wellformed();
                // Cut the frame short by dropping its newest bytes
                if (frame_bytes.size() > 1) begin
                    keep = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > keep) void'(frame_bytes.pop_front());
                end
            end else begin
                keep = $urandom_range(1, 24);
                for (int i = 0; i < keep; i++) frame_bytes.push_front(8'($urandom_range(255)));
            end
            queue_frame();
        end
        total_items   = byte_stream.size();
        pause_mark[0] = directed_items;
        pause_mark[1] = directed_items + 400;
    endtask

    // Driver: offer bytes, track transfers, feed the predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_data);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pause_idx < 2 && issued_count == pause_mark[pause_idx]) begin
                    // Hold until the block has drained
                    if (expected_results.size() == 0) pause_idx++;
                    s_valid <= 1'b0;
                end else if (byte_stream.size() > 0 &&
                             !((accepted_count < 350 || accepted_count >= 550) &&
                               $urandom_range(99) < 12)) begin
                    s_data  <= byte_stream.pop_back();
                    s_valid <= 1'b1;
                    issued_count++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, drive ready with idles and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !((results_seen < 400 || results_seen >= 600) &&
                             $urandom_range(99) < 12);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("lldp_tlv_parser_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        clear_frame_state();
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_count != total_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("lldp_tlv_parser_unit_tb OK");
        else
            $display("lldp_tlv_parser_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
rtl/lldp_pkg.sv
rtl/lldp_front.sv
rtl/lldp_queue.sv
rtl/lldp_back.sv
rtl/lldp_tlv_parser_unit.sv
tb/sv/lldp_tlv_parser_unit_tb.sv
